// ===== hdl/qrs_pkg.sv =====
// Shared constants for the quadratic root solver.
package qrs_pkg;

    localparam int COEF_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    // Fixed result field widths.
    localparam int ROOT_W = 34;
    localparam int VY_W   = 49;

    // Division lanes.
    localparam int LANES     = 4;
    localparam int LANE_RP   = 0;
    localparam int LANE_RM   = 1;
    localparam int LANE_VX   = 2;
    localparam int LANE_VY   = 3;

    typedef enum logic [1:0] {
        STAT_REAL     = 2'd0,
        STAT_NOT_QUAD = 2'd1,
        STAT_NO_REAL  = 2'd2
    } status_t;

endpackage

// ===== hdl/qrs_sqrt_cell.sv =====
// One bit stage of the pipelined integer square root.
module qrs_sqrt_cell #(
    parameter int RB = 33,
    parameter int SW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2*RB-1:0]   in_x,
    input  logic [RB+1:0]     in_rem,
    input  logic [RB-1:0]     in_root,
    input  logic [SW-1:0]     in_side,
    output logic              out_valid,
    output logic [2*RB-1:0]   out_x,
    output logic [RB+1:0]     out_rem,
    output logic [RB-1:0]     out_root,
    output logic [SW-1:0]     out_side
);

    localparam int RW = RB + 2;

    logic              valid_reg;
    logic [2*RB-1:0]   x_reg;
    logic [RW-1:0]     rem_reg;
    logic [RB-1:0]     root_reg;
    logic [SW-1:0]     side_reg;

    logic [RW-1:0]     rem_t;
    logic [RW-1:0]     trial;
    logic              ge;
    logic [2*RB-1:0]   x_next;
    logic [RW-1:0]     rem_next;
    logic [RB-1:0]     root_next;

    always_comb
    begin
        rem_t     = {in_rem[RW-3:0], in_x[2*RB-1 -: 2]};
        trial     = {in_root, 2'b01};
        ge        = (rem_t >= trial);
        x_next    = in_x << 2;
        rem_next  = ge ? (rem_t - trial) : rem_t;
        root_next = {in_root[RB-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

// ===== hdl/qrs_div_cell.sv =====
// One quotient-bit stage of the multi-lane restoring divider.
module qrs_div_cell #(
    parameter int NUMW  = 49,
    parameter int DVW   = 18,
    parameter int LANES = 4,
    parameter int SW    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [LANES-1:0][NUMW-1:0]  in_num,
    input  logic [LANES-1:0][DVW-1:0]   in_den,
    input  logic [LANES-1:0][DVW-1:0]   in_rem,
    input  logic [LANES-1:0][NUMW-1:0]  in_quo,
    input  logic [SW-1:0]               in_side,
    output logic                        out_valid,
    output logic [LANES-1:0][NUMW-1:0]  out_num,
    output logic [LANES-1:0][DVW-1:0]   out_den,
    output logic [LANES-1:0][DVW-1:0]   out_rem,
    output logic [LANES-1:0][NUMW-1:0]  out_quo,
    output logic [SW-1:0]               out_side
);

    logic                        valid_reg;
    logic [LANES-1:0][NUMW-1:0]  num_reg;
    logic [LANES-1:0][DVW-1:0]   den_reg;
    logic [LANES-1:0][DVW-1:0]   rem_reg;
    logic [LANES-1:0][NUMW-1:0]  quo_reg;
    logic [SW-1:0]               side_reg;

    logic [LANES-1:0][NUMW-1:0]  num_next;
    logic [LANES-1:0][DVW-1:0]   rem_next;
    logic [LANES-1:0][NUMW-1:0]  quo_next;

    always_comb
    begin
        logic [DVW:0] rem_t;
        logic [DVW:0] den_x;
        logic         ge;
        for (int l = 0; l < LANES; l++)
        begin
            rem_t       = {in_rem[l], in_num[l][NUMW-1]};
            den_x       = {1'b0, in_den[l]};
            ge          = (rem_t >= den_x);
            rem_next[l] = ge ? DVW'(rem_t - den_x) : DVW'(rem_t);
            num_next[l] = in_num[l] << 1;
            quo_next[l] = {in_quo[l][NUMW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= in_den;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        side_reg <= in_side;
    end

    assign out_valid = valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

// ===== hdl/quadratic_root_solver_unit.sv =====
// Top level: pipelined quadratic solver (discriminant, square root, divides).
//
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+----------------------------
//  item in  | coef_a, coef_b, coef_c              | start high, busy low
//  item out | status, root_plus, root_minus,      | done high for one cycle
//           | vertex_x, vertex_y, opens_up        |
//
// One item enters every cycle; busy is always low. Each item passes the
// capture, product and discriminant registers, the square-root cell chain
// (RB cells, one root bit each), the prep register and the divider cell
// chain (NUMW cells, one quotient bit each), then the output register.
// Reset clears only the valid bits along the chains; payload is not reset.
// The receiver cannot stall, so results leave on done unconditionally.
module quadratic_root_solver_unit #(
    parameter int COEF_BITS = qrs_pkg::COEF_BITS_DEF,
    parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COEF_BITS-1:0]         coef_a,
    input  logic signed [COEF_BITS-1:0]         coef_b,
    input  logic signed [COEF_BITS-1:0]         coef_c,
    output logic                                done,
    output logic [1:0]                          status,
    output logic signed [qrs_pkg::ROOT_W-1:0]   root_plus,
    output logic signed [qrs_pkg::ROOT_W-1:0]   root_minus,
    output logic signed [qrs_pkg::ROOT_W-1:0]   vertex_x,
    output logic signed [qrs_pkg::VY_W-1:0]     vertex_y,
    output logic                                opens_up
);

    localparam int N     = COEF_BITS;
    localparam int F     = FRAC_BITS;
    localparam int DW    = 2 * N + 2;          // signed discriminant
    localparam int DUW   = 2 * N + 1;          // nonnegative discriminant
    localparam int XW    = DUW + 2 * F;        // scaled radicand
    localparam int RB    = (XW + 1) / 2;       // root bits = sqrt cells
    localparam int NBW   = N + F + 1;          // -b * 2^F, signed
    localparam int RNW   = ((N - 1 + F > RB) ? N - 1 + F : RB) + 1;
    localparam int VNW   = DUW + F;
    localparam int NUMW  = (RNW > VNW) ? RNW : VNW;
    localparam int DVW   = N + 2;              // 4|a| fits
    localparam int LN    = qrs_pkg::LANES;
    localparam int SQW   = 2 * N + DUW + 3;
    localparam int DSW   = 3 + LN;

    // ---------------- stage 0: capture ----------------
    logic                   v0_reg;
    logic signed [N-1:0]    a0_reg, b0_reg, c0_reg;

    // ---------------- stage 1: products ----------------
    logic                   v1_reg;
    logic signed [N-1:0]    a1_reg, b1_reg;
    logic signed [2*N-1:0]  bb1_reg, ac1_reg;
    logic signed [2*N-1:0]  bb1_next, ac1_next;

    // ---------------- stage 2: discriminant and status ----------------
    logic                   v2_reg;
    logic signed [N-1:0]    a2_reg, b2_reg;
    logic [DUW-1:0]         d2_reg;
    logic [1:0]             st2_reg;
    logic                   up2_reg;
    logic signed [DW-1:0]   d2_next;
    logic [1:0]             st2_next;
    logic                   up2_next;

    assign busy = 1'b0;

    always_comb
    begin
        bb1_next = (2 * N)'(b0_reg) * (2 * N)'(b0_reg);
        ac1_next = (2 * N)'(a0_reg) * (2 * N)'(c0_reg);
    end

    always_comb
    begin
        d2_next  = DW'(bb1_reg) - (DW'(ac1_reg) <<< 2);
        up2_next = (a1_reg != '0) && !a1_reg[N-1];
        if (a1_reg == '0)
        begin
            st2_next = qrs_pkg::STAT_NOT_QUAD;
        end
        else if (d2_next[DW-1])
        begin
            st2_next = qrs_pkg::STAT_NO_REAL;
        end
        else
        begin
            st2_next = qrs_pkg::STAT_REAL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a0_reg  <= coef_a;
        b0_reg  <= coef_b;
        c0_reg  <= coef_c;
        a1_reg  <= a0_reg;
        b1_reg  <= b0_reg;
        bb1_reg <= bb1_next;
        ac1_reg <= ac1_next;
        a2_reg  <= a1_reg;
        b2_reg  <= b1_reg;
        d2_reg  <= d2_next[DUW-1:0];
        st2_reg <= st2_next;
        up2_reg <= up2_next;
    end

    // ---------------- square root chain: one root bit per cell ----------------
    // Radicand is D * 4^F; a negative D yields junk that is zeroed at the end.
    logic                 sq_valid [RB+1];
    logic [2*RB-1:0]      sq_x     [RB+1];
    logic [RB+1:0]        sq_rem   [RB+1];
    logic [RB-1:0]        sq_root  [RB+1];
    logic [SQW-1:0]       sq_side  [RB+1];

    assign sq_valid[0] = v2_reg;
    assign sq_x[0]     = (2 * RB)'(d2_reg) << (2 * F);
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {a2_reg, b2_reg, d2_reg, st2_reg, up2_reg};

    for (genvar g = 0; g < RB; g++)
    begin : g_sq
        qrs_sqrt_cell #(
            .RB (RB),
            .SW (SQW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[g]),
            .in_x      (sq_x[g]),
            .in_rem    (sq_rem[g]),
            .in_root   (sq_root[g]),
            .in_side   (sq_side[g]),
            .out_valid (sq_valid[g+1]),
            .out_x     (sq_x[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_root  (sq_root[g+1]),
            .out_side  (sq_side[g+1])
        );
    end

    // ---------------- prep: numerators, divisors, result signs ----------------
    logic signed [N-1:0]        pa, pb;
    logic [DUW-1:0]             pd;
    logic [1:0]                 pst;
    logic                       pup;
    logic signed [NBW-1:0]      nb;
    logic signed [RNW:0]        sum_p, sum_m;
    logic [N:0]                 a_mag;
    logic                       a_neg;

    logic                         pv_reg;
    logic [LN-1:0][NUMW-1:0]      pnum_reg, pnum_next;
    logic [LN-1:0][DVW-1:0]       pden_reg, pden_next;
    logic [DSW-1:0]               pside_reg, pside_next;
    logic [LN-1:0]                neg_next;

    function automatic logic [NUMW-1:0] mag_sum(input logic signed [RNW:0] v);
        logic signed [RNW:0] m;
        m = v[RNW] ? -v : v;
        return NUMW'(m[RNW-1:0]);
    endfunction

    function automatic logic [NUMW-1:0] mag_nb(input logic signed [NBW-1:0] v);
        logic signed [NBW-1:0] m;
        m = v[NBW-1] ? -v : v;
        return NUMW'(m[NBW-2:0]);
    endfunction

    always_comb
    begin
        {pa, pb, pd, pst, pup} = sq_side[RB];
        a_neg = pa[N-1];
        a_mag = a_neg ? -((N+1)'(pa)) : (N+1)'(pa);
        nb    = (-(NBW'(pb))) <<< F;
        sum_p = (RNW+1)'(nb) + (RNW+1)'($signed({1'b0, sq_root[RB]}));
        sum_m = (RNW+1)'(nb) - (RNW+1)'($signed({1'b0, sq_root[RB]}));

        pnum_next[qrs_pkg::LANE_RP] = mag_sum(sum_p);
        pnum_next[qrs_pkg::LANE_RM] = mag_sum(sum_m);
        pnum_next[qrs_pkg::LANE_VX] = mag_nb(nb);
        pnum_next[qrs_pkg::LANE_VY] = NUMW'(pd) << F;

        pden_next[qrs_pkg::LANE_RP] = DVW'(a_mag) << 1;
        pden_next[qrs_pkg::LANE_RM] = DVW'(a_mag) << 1;
        pden_next[qrs_pkg::LANE_VX] = DVW'(a_mag) << 1;
        pden_next[qrs_pkg::LANE_VY] = DVW'(a_mag) << 2;

        // quotient sign: numerator sign xor divisor sign; -D/(4a) negative when a > 0
        neg_next[qrs_pkg::LANE_RP] = sum_p[RNW] ^ a_neg;
        neg_next[qrs_pkg::LANE_RM] = sum_m[RNW] ^ a_neg;
        neg_next[qrs_pkg::LANE_VX] = nb[NBW-1] ^ a_neg;
        neg_next[qrs_pkg::LANE_VY] = pup;

        pside_next = {pst, pup, neg_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= sq_valid[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        pnum_reg  <= pnum_next;
        pden_reg  <= pden_next;
        pside_reg <= pside_next;
    end

    // ---------------- divider chain: one quotient bit per cell, four lanes ----------------
    logic                        dv_valid [NUMW+1];
    logic [LN-1:0][NUMW-1:0]     dv_num   [NUMW+1];
    logic [LN-1:0][DVW-1:0]      dv_den   [NUMW+1];
    logic [LN-1:0][DVW-1:0]      dv_rem   [NUMW+1];
    logic [LN-1:0][NUMW-1:0]     dv_quo   [NUMW+1];
    logic [DSW-1:0]              dv_side  [NUMW+1];

    assign dv_valid[0] = pv_reg;
    assign dv_num[0]   = pnum_reg;
    assign dv_den[0]   = pden_reg;
    assign dv_rem[0]   = '0;
    assign dv_quo[0]   = '0;
    assign dv_side[0]  = pside_reg;

    for (genvar g = 0; g < NUMW; g++)
    begin : g_dv
        qrs_div_cell #(
            .NUMW  (NUMW),
            .DVW   (DVW),
            .LANES (LN),
            .SW    (DSW)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[g]),
            .in_num    (dv_num[g]),
            .in_den    (dv_den[g]),
            .in_rem    (dv_rem[g]),
            .in_quo    (dv_quo[g]),
            .in_side   (dv_side[g]),
            .out_valid (dv_valid[g+1]),
            .out_num   (dv_num[g+1]),
            .out_den   (dv_den[g+1]),
            .out_rem   (dv_rem[g+1]),
            .out_quo   (dv_quo[g+1]),
            .out_side  (dv_side[g+1])
        );
    end

    // ---------------- output: apply signs, zero when not solved ----------------
    logic [1:0]                   fst;
    logic                         fup;
    logic [LN-1:0]                fneg;
    logic signed [LN-1:0][NUMW:0] sres;

    logic                              done_reg;
    logic [1:0]                        status_reg, status_next;
    logic signed [qrs_pkg::ROOT_W-1:0] rp_reg, rp_next;
    logic signed [qrs_pkg::ROOT_W-1:0] rm_reg, rm_next;
    logic signed [qrs_pkg::ROOT_W-1:0] vx_reg, vx_next;
    logic signed [qrs_pkg::VY_W-1:0]   vy_reg, vy_next;
    logic                              up_reg, up_next;

    always_comb
    begin
        {fst, fup, fneg} = dv_side[NUMW];
        for (int l = 0; l < LN; l++)
        begin
            sres[l] = fneg[l] ? -$signed({1'b0, dv_quo[NUMW][l]})
                              : $signed({1'b0, dv_quo[NUMW][l]});
        end
        status_next = fst;
        up_next     = fup;
        if (fst == qrs_pkg::STAT_REAL)
        begin
            rp_next = qrs_pkg::ROOT_W'(sres[qrs_pkg::LANE_RP]);
            rm_next = qrs_pkg::ROOT_W'(sres[qrs_pkg::LANE_RM]);
            vx_next = qrs_pkg::ROOT_W'(sres[qrs_pkg::LANE_VX]);
            vy_next = qrs_pkg::VY_W'(sres[qrs_pkg::LANE_VY]);
        end
        else
        begin
            rp_next = '0;
            rm_next = '0;
            vx_next = '0;
            vy_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_valid[NUMW];
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rp_reg     <= rp_next;
        rm_reg     <= rm_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        up_reg     <= up_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign root_plus  = rp_reg;
    assign root_minus = rm_reg;
    assign vertex_x   = vx_reg;
    assign vertex_y   = vy_reg;
    assign opens_up   = up_reg;

endmodule

// ===== dv/quadratic_root_solver_unit_test.sv =====
// Testbench for the quadratic root solver: directed table plus random coefficient sets.
`timescale 1ns / 1ps

module quadratic_root_solver_unit_test;

    localparam int CB = qrs_pkg::COEF_BITS_DEF;
    localparam int FB = qrs_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 87;
    localparam int N_RANDOM = 500;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]                 status;
        logic [qrs_pkg::ROOT_W-1:0] root_plus;
        logic [qrs_pkg::ROOT_W-1:0] root_minus;
        logic [qrs_pkg::ROOT_W-1:0] vertex_x;
        logic [qrs_pkg::VY_W-1:0]   vertex_y;
        logic                       opens_up;
    } solution_t;

    // One row of directed stimulus; has_gold marks rows with a typed-in answer.
    typedef struct {
        logic [CB-1:0] a;
        logic [CB-1:0] b;
        logic [CB-1:0] c;
        bit            has_gold;
        solution_t     gold;
    } coef_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [CB-1:0] coef_a;
    logic signed [CB-1:0] coef_b;
    logic signed [CB-1:0] coef_c;
    logic done;
    logic [1:0] status;
    logic signed [qrs_pkg::ROOT_W-1:0] root_plus;
    logic signed [qrs_pkg::ROOT_W-1:0] root_minus;
    logic signed [qrs_pkg::ROOT_W-1:0] vertex_x;
    logic signed [qrs_pkg::VY_W-1:0] vertex_y;
    logic opens_up;

    solution_t pending_solutions[$];
    int  mismatch_count;
    int  items_sent;
    int  results_seen;
    longint cycle_count;

    quadratic_root_solver_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .done(done), .status(status), .root_plus(root_plus),
        .root_minus(root_minus), .vertex_x(vertex_x), .vertex_y(vertex_y),
        .opens_up(opens_up)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Exact digit-by-digit root of d * 4^FB: floor(sqrt(d) * 2^FB).
    function automatic longint unsigned scaled_sqrt(longint unsigned d);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned pair;
        longint unsigned trial;
        root = 0;
        rem = 0;
        for (int i = 31 + FB; i >= 0; i--)
        begin
            pair = 0;
            if (i >= FB)
                pair = (d >> (2 * (i - FB))) & 64'd3;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    // Quadratic formula in fixed point; SV signed division truncates toward zero.
    function automatic solution_t solve_quadratic(logic signed [CB-1:0] a_in,
                                                  logic signed [CB-1:0] b_in,
                                                  logic signed [CB-1:0] c_in);
        solution_t sol;
        longint a;
        longint b;
        longint c;
        longint disc;
        longint sq;
        longint nb;
        longint den2;
        longint unsigned den4;
        longint unsigned q;
        longint unsigned r;
        longint unsigned mag;
        a = a_in;
        b = b_in;
        c = c_in;
        sol = '0;
        sol.opens_up = (a > 0);
        if (a == 0)
            sol.status = qrs_pkg::STAT_NOT_QUAD;
        else
        begin
            disc = b * b - 4 * a * c;
            if (disc < 0)
                sol.status = qrs_pkg::STAT_NO_REAL;
            else
            begin
                sol.status = qrs_pkg::STAT_REAL;
                sq = longint'(scaled_sqrt(longint'(disc)));
                nb = -b * (longint'(1) << FB);
                den2 = 2 * a;
                den4 = longint'(a < 0 ? -a : a) * 4;
                q = longint'(disc) / den4;
                r = longint'(disc) % den4;
                mag = (q << FB) + ((r << FB) / den4);
                sol.root_plus = qrs_pkg::ROOT_W'((nb + sq) / den2);
                sol.root_minus = qrs_pkg::ROOT_W'((nb - sq) / den2);
                sol.vertex_x = qrs_pkg::ROOT_W'(nb / den2);
                sol.vertex_y = qrs_pkg::VY_W'((a > 0) ? (64'd0 - mag) : mag);
            end
        end
        return sol;
    endfunction

    // Drive one item at the falling edge, hold until it is taken at a rising edge.
    task automatic send_coefs(logic [CB-1:0] a, logic [CB-1:0] b, logic [CB-1:0] c,
                              solution_t want);
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_solutions.push_back(want);
        items_sent++;
        @(negedge clk);
    endtask

    // Random gap: mostly zero or short, occasionally long; start drops here and in drain.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) < 6) ? 0 :
            (($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 120));
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending_solutions.size() != 0)
            @(negedge clk);
    endtask

    // Result checker: results arrive unconditionally on done.
    always @(posedge clk)
    begin
        solution_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_solutions.size() == 0)
            begin
                $error("result with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = pending_solutions.pop_front();
                if (status !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, status);
                    mismatch_count++;
                end
                if (root_plus !== want.root_plus)
                begin
                    $error("root_plus exp %h got %h", want.root_plus, root_plus);
                    mismatch_count++;
                end
                if (root_minus !== want.root_minus)
                begin
                    $error("root_minus exp %h got %h", want.root_minus, root_minus);
                    mismatch_count++;
                end
                if (vertex_x !== want.vertex_x)
                begin
                    $error("vertex_x exp %h got %h", want.vertex_x, vertex_x);
                    mismatch_count++;
                end
                if (vertex_y !== want.vertex_y)
                begin
                    $error("vertex_y exp %h got %h", want.vertex_y, vertex_y);
                    mismatch_count++;
                end
                if (opens_up !== want.opens_up)
                begin
                    $error("opens_up exp %0d got %0d", want.opens_up, opens_up);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic coef_row_t row(int a, int b, int c);
        coef_row_t rr;
        rr.a = CB'(a);
        rr.b = CB'(b);
        rr.c = CB'(c);
        rr.has_gold = 1'b0;
        rr.gold = '0;
        return rr;
    endfunction

    function automatic coef_row_t gold_row(int a, int b, int c, qrs_pkg::status_t st,
                                           bit up);
        coef_row_t rr;
        rr = row(a, b, c);
        rr.has_gold = 1'b1;
        rr.gold.status = st;
        rr.gold.opens_up = up;
        return rr;
    endfunction

    initial
    begin
        coef_row_t directed[$];
        coef_row_t rw;
        solution_t want;
        logic [CB-1:0] ra;
        logic [CB-1:0] rb;
        logic [CB-1:0] rc;
        int kind;

        mismatch_count = 0;
        items_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        coef_a = '0;
        coef_b = '0;
        coef_c = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Not quadratic: a zero, all else zero, opens_up low.
        directed.push_back(gold_row(0, 0, 0, qrs_pkg::STAT_NOT_QUAD, 1'b0));
        directed.push_back(gold_row(0, 32767, -32768, qrs_pkg::STAT_NOT_QUAD, 1'b0));
        directed.push_back(gold_row(0, -32768, 32767, qrs_pkg::STAT_NOT_QUAD, 1'b0));
        // No real roots: flag still follows sign of a.
        directed.push_back(gold_row(1, 0, 1, qrs_pkg::STAT_NO_REAL, 1'b1));
        directed.push_back(gold_row(-1, 0, -1, qrs_pkg::STAT_NO_REAL, 1'b0));
        directed.push_back(gold_row(32767, 0, 32767, qrs_pkg::STAT_NO_REAL, 1'b1));
        directed.push_back(gold_row(-32768, 0, -32768, qrs_pkg::STAT_NO_REAL, 1'b0));
        // Double roots (zero discriminant).
        directed.push_back(row(1, 2, 1));
        directed.push_back(row(-1, 2, -1));
        directed.push_back(row(4, -4, 1));
        directed.push_back(row(1, 0, 0));
        // Ordinary two roots, both signs of a.
        directed.push_back(row(1, -3, 2));
        directed.push_back(row(-2, 5, 3));
        directed.push_back(row(3, 7, -11));
        // Extremes: largest discriminants and smallest denominators.
        directed.push_back(row(1, -32768, -32768));
        directed.push_back(row(-32768, -32768, 32767));
        directed.push_back(row(32767, 32767, -32768));
        directed.push_back(row(-32768, 32767, 32767));
        directed.push_back(row(1, 32767, 0));
        directed.push_back(row(-1, -32768, 32767));
        directed.push_back(row(32767, -32768, 0));
        directed.push_back(row(-32768, 0, 32767));
        directed.push_back(row(-1, -1, -1));

        foreach (directed[i])
        begin
            rw = directed[i];
            want = solve_quadratic(rw.a, rw.b, rw.c);
            if (rw.has_gold)
                want = rw.gold;
            send_coefs(rw.a, rw.b, rw.c, want);
            if (i % 5 == 4)
                idle_gap();
        end

        // Sender holds off until the pipe is empty.
        drain();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Bias toward sets with real roots so the deep datapath is exercised.
            kind = $urandom_range(0, 9);
            ra = CB'($urandom);
            rb = CB'($urandom);
            rc = CB'($urandom);
            if (kind < 2)
            begin
                ra = CB'($urandom_range(0, 15)) - CB'(8);
                rb = CB'($urandom_range(0, 63)) - CB'(32);
                rc = CB'($urandom_range(0, 63)) - CB'(32);
            end
            else if (kind < 6)
                rc = (ra[CB-1] ^ rc[CB-1]) ? rc : -rc;
            else if (kind == 6)
                ra = '0;
            send_coefs(ra, rb, rc, solve_quadratic(ra, rb, rc));
            idle_gap();
            if (n == N_RANDOM / 2)
                drain();
        end

        drain();
        repeat (LATENCY + 10) @(negedge clk);

        $display("Ran %0d coefficient sets (directed extremes, double roots, %s",
                 items_sent, "degenerate and complex cases, then random)");
        $display("Checked %0d results against the predicted solutions", results_seen);
        if (mismatch_count == 0 && pending_solutions.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
